@@ hw/rtl/rcmr_pkg.sv @@
// Shared constants for the rod cutting best-revenue block.
package rcmr_pkg;

    // Default sizing for the top-level and submodule parameters
    localparam int DEF_MAX_LENGTH  = 256;
    localparam int DEF_PRICE_WIDTH = 16;

    // Fixed field widths
    localparam int CFG_W = 9;
    localparam int REV_W = 24;

    // Revenue saturation ceiling
    localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

endpackage

@@ hw/rtl/rcmr_front.sv @@
// Front end: length register, price intake and load counting.
module rcmr_front
    import rcmr_pkg::*;
#(
    parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
    parameter int PRICE_WIDTH = DEF_PRICE_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [CFG_W-1:0]                   cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [PRICE_WIDTH-1:0]             s_price,
    output logic                               push_valid,
    input  logic                               push_ready,
    output logic [PRICE_WIDTH-1:0]             push_price,
    output logic [$clog2(MAX_LENGTH)-1:0]      push_addr,
    output logic                               push_last
);

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);

    logic [CFG_W-1:0]  rod_length_reg;
    logic [ADDR_W-1:0] load_count_reg;
    logic [ADDR_W-1:0] load_count_next;
    logic [31:0]       rod_wide;
    logic [LEN_W-1:0]  eff_len;
    logic              last_item;
    logic              xfer;

    // Effective length: zero counts as one, large values clip to the store depth
    always_comb begin
        rod_wide = 32'(rod_length_reg);
        if (rod_wide == 32'd0) begin
            eff_len = LEN_W'(1);
        end else if (rod_wide > 32'(MAX_LENGTH)) begin
            eff_len = LEN_W'(MAX_LENGTH);
        end else begin
            eff_len = rod_wide[LEN_W-1:0];
        end
    end

    assign xfer      = s_tvalid && s_tready;
    assign last_item = (LEN_W'(load_count_reg) + LEN_W'(1)) == eff_len;

    // Classified item toward the queue
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign push_price = s_price;
    assign push_addr  = load_count_reg;
    assign push_last  = last_item;

    always_comb begin
        load_count_next = load_count_reg;
        if (cfg_wr_en) begin
            load_count_next = '0;
        end else if (xfer) begin
            load_count_next = last_item ? '0 : load_count_reg + ADDR_W'(1);
        end
    end

    // Length register and load counter; a length write restarts the load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rod_length_reg <= CFG_W'(1);
            load_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                rod_length_reg <= cfg_wr_data;
            end
            load_count_reg <= load_count_next;
        end
    end

endmodule

@@ hw/rtl/rcmr_queue.sv @@
// Two-entry queue between the front end and the solver.
module rcmr_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ hw/rtl/rcmr_back.sv @@
// Solver: price and revenue memories, row/cut sequencer and result register.
module rcmr_back
    import rcmr_pkg::*;
#(
    parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
    parameter int PRICE_WIDTH = DEF_PRICE_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  logic [PRICE_WIDTH-1:0]             pop_price,
    input  logic [$clog2(MAX_LENGTH)-1:0]      pop_addr,
    input  logic                               pop_last,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [REV_W-1:0]                   m_revenue
);

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int SUM_W  = ((PRICE_WIDTH > REV_W) ? PRICE_WIDTH : REV_W) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [PRICE_WIDTH-1:0] price_mem [MAX_LENGTH];
    logic [REV_W-1:0]       rev_mem   [MAX_LENGTH];

    logic [1:0]             state_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       i_reg;
    logic [LEN_W-1:0]       j_reg;
    logic                   pv_reg;
    logic [REV_W-1:0]       best_reg;
    logic [PRICE_WIDTH-1:0] rd_price_reg;
    logic [REV_W-1:0]       rd_rev_reg;
    logic                   out_valid_reg;
    logic [REV_W-1:0]       out_data_reg;

    logic                   pop_fire;
    logic                   issue;
    logic                   row_last;
    logic                   write_go;
    logic [ADDR_W-1:0]      price_addr;
    logic [ADDR_W-1:0]      rev_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [REV_W-1:0]       rev_op;
    logic [SUM_W-1:0]       sum;
    logic [REV_W-1:0]       cand;
    logic [REV_W-1:0]       best_upd;

    assign pop_ready = state_reg == ST_IDLE;
    assign pop_fire  = pop_valid && pop_ready;
    assign issue     = state_reg == ST_CALC;
    assign row_last  = j_reg == len_reg;

    // Read addresses: price of cut i, revenue of the remainder j-i (stored at j-i-1)
    assign price_addr = ADDR_W'(i_reg - LEN_W'(1));
    assign rev_addr   = ADDR_W'(j_reg - i_reg - LEN_W'(1));
    assign wr_addr    = ADDR_W'(j_reg - LEN_W'(1));

    // Candidate: the read in the write slot is always the whole-piece cut (remainder 0)
    assign rev_op   = (state_reg == ST_WRITE) ? '0 : rd_rev_reg;
    assign sum      = SUM_W'(rd_price_reg) + SUM_W'(rev_op);
    assign cand     = (sum > SUM_W'(REV_MAX)) ? REV_MAX : sum[REV_W-1:0];
    assign best_upd = (cand > best_reg) ? cand : best_reg;

    // Final row waits while the previous result is still unclaimed
    assign write_go = (state_reg == ST_WRITE) && (!row_last || !out_valid_reg || m_tready);

    assign m_tvalid  = out_valid_reg;
    assign m_revenue = out_data_reg;

    // Memories
    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            price_mem[pop_addr] <= pop_price;
        end
        if (issue) begin
            rd_price_reg <= price_mem[price_addr];
            rd_rev_reg   <= rev_mem[rev_addr];
        end
        if (write_go) begin
            rev_mem[wr_addr] <= best_upd;
        end
    end

    // Result data
    always_ff @(posedge aclk) begin
        if (write_go && row_last) begin
            out_data_reg <= best_upd;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_W'(1);
            i_reg         <= LEN_W'(1);
            j_reg         <= LEN_W'(1);
            pv_reg        <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pv_reg <= issue;
            // Result valid: set by the final row write, cleared by a transfer
            if (write_go && row_last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop_fire && pop_last) begin
                        len_reg   <= LEN_W'(pop_addr) + LEN_W'(1);
                        i_reg     <= LEN_W'(1);
                        j_reg     <= LEN_W'(1);
                        best_reg  <= '0;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (pv_reg) begin
                        best_reg <= best_upd;
                    end
                    if (i_reg == j_reg) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        i_reg <= i_reg + LEN_W'(1);
                    end
                end
                ST_WRITE: begin
                    if (write_go) begin
                        best_reg <= '0;
                        if (row_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            j_reg     <= j_reg + LEN_W'(1);
                            i_reg     <= LEN_W'(1);
                            state_reg <= ST_CALC;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/rod_cutting_max_revenue.sv @@
// Top level of the rod cutting best-revenue block.
//
//  channel   dir  signals                          contents
//  s_        in   s_tvalid/s_tready/s_tdata        piece prices, lengths 1..L in order
//  m_        out  m_tvalid/m_tready/m_tdata        best revenue for the full rod
//  cfg_      in   cfg_wr_en/cfg_wr_data            rod length L (0 means 1)
//
// Prices are taken one per cycle through a two-entry queue into the price memory.
// After the L-th price the solver runs rows j = 1..L in turn, each as one memory read pair
// per cut and then one write slot; the revenue memory is read through a register.
// Input stalls once the queue fills during a solve.
// Reset clears control state only; the memories need no clearing.
module rod_cutting_max_revenue
    import rcmr_pkg::*;
#(
    parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
    parameter int PRICE_WIDTH = DEF_PRICE_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_W-1:0]                       cfg_wr_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata: piece_price [PRICE_WIDTH-1:0], zero pad above
    input  logic [((PRICE_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata: best_revenue [23:0]
    output logic [REV_W-1:0]                       m_tdata
);

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int ITEM_W = PRICE_WIDTH + ADDR_W + 1;

    logic                   push_valid;
    logic                   push_ready;
    logic [PRICE_WIDTH-1:0] push_price;
    logic [ADDR_W-1:0]      push_addr;
    logic                   push_last;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [ITEM_W-1:0]      pop_data;

    // Intake
    rcmr_front #(
        .MAX_LENGTH  (MAX_LENGTH),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_price     (s_tdata[PRICE_WIDTH-1:0]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_price  (push_price),
        .push_addr   (push_addr),
        .push_last   (push_last)
    );

    // Decoupling queue: {last, addr, price}
    rcmr_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_last, push_addr, push_price}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Solver
    rcmr_back #(
        .MAX_LENGTH  (MAX_LENGTH),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_price (pop_data[PRICE_WIDTH-1:0]),
        .pop_addr  (pop_data[PRICE_WIDTH +: ADDR_W]),
        .pop_last  (pop_data[ITEM_W-1]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_revenue (m_tdata)
    );

endmodule
